FILE: hdl/tlt_pkg.sv
package tlt_pkg;

  // Table geometry
  localparam int TRACK_SLOTS = 64;
  localparam int COUNT_BITS  = 16;
  localparam int SLOT_BITS   = $clog2(TRACK_SLOTS);
  localparam int CW          = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  localparam int Q_BITS      = 17;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 20;

  localparam logic [Q_BITS-1:0] Q_ONE = 17'h10000;

  // Classification thresholds: squared speed in (1/16 m/s)^2, probabilities Q1.16
  localparam logic [31:0] SPD2_2  = 32'd1024;
  localparam logic [31:0] SPD2_5  = 32'd6400;
  localparam logic [31:0] SPD2_15 = 32'd57600;
  localparam logic [31:0] SPD2_25 = 32'd160000;
  localparam logic [31:0] SPD2_30 = 32'd230400;
  localparam logic [31:0] SPD2_80 = 32'd1638400;
  localparam logic [Q_BITS-1:0] PROB_0P4 = 17'd26214;
  localparam logic [Q_BITS-1:0] PROB_0P3 = 17'd19660;

  typedef logic [COUNT_BITS-1:0] cnt_t;
  localparam cnt_t CNT_MAX = '1;

  typedef enum logic {
    OP_CREATE = 1'b0,
    OP_UPDATE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_TENT  = 2'd1,
    ST_CONF  = 2'd2,
    ST_COAST = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CLS_UNKNOWN    = 3'd0,
    CLS_CLUTTER    = 3'd1,
    CLS_ROTARY     = 3'd2,
    CLS_FIXED_WING = 3'd3,
    CLS_BIRD       = 3'd4
  } class_e;

  typedef enum logic {
    RC_OK        = 1'b0,
    RC_FREE_SLOT = 1'b1
  } rc_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_QUALITY_BOOST     = 3'd0,
    CFG_QUALITY_DECAY     = 3'd1,
    CFG_CONFIRM_HIT_COUNT = 3'd2,
    CFG_MAX_COAST_MISSES  = 3'd3,
    CFG_MIN_QUALITY       = 3'd4,
    CFG_MAX_TRACK_RANGE   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [Q_BITS-1:0] quality_boost;
    logic [Q_BITS-1:0] quality_decay;
    logic [15:0]       confirm_hit_count;
    logic [15:0]       max_coast_misses;
    logic [Q_BITS-1:0] min_quality;
    logic [19:0]       max_track_range;
  } cfg_t;

  // One slot of the track table
  typedef struct packed {
    status_e           status;
    logic [Q_BITS-1:0] quality;
    cnt_t              hits;
    cnt_t              misses;
    class_e            cls;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  typedef struct packed {
    op_e               op;
    logic [5:0]        slot;
    logic              hit;
    logic [Q_BITS-1:0] init_quality;
    logic [15:0]       init_hits;
    logic [19:0]       range_m;
    logic [15:0]       vel_x;
    logic [15:0]       vel_y;
    logic [15:0]       vel_z;
    logic [Q_BITS-1:0] cv_prob;
    logic [Q_BITS-1:0] ca_prob;
    logic [Q_BITS-1:0] turn_prob;
  } item_t;

  typedef struct packed {
    logic [5:0]        slot;
    status_e           status;
    class_e            cls;
    logic [Q_BITS-1:0] quality;
    logic [15:0]       hit_total;
    logic [15:0]       miss_run;
    rc_e               code;
  } result_t;

  // Low 16 bits of a counter, zero-extended when the counter is narrower
  function automatic logic [15:0] cnt_to16(cnt_t c);
    logic [CW-1:0] w;
    w = CW'(c);
    return w[15:0];
  endfunction

endpackage

FILE: hdl/tlt_ram.sv
module tlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/tlt_cfg_regs.sv
module tlt_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tlt_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [tlt_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  output tlt_pkg::cfg_t                      cfg_o
);
  import tlt_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  // Decode the register index
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_QUALITY_BOOST:     cfg_d.quality_boost     = cfg_data_i[Q_BITS-1:0];
        CFG_QUALITY_DECAY:     cfg_d.quality_decay     = cfg_data_i[Q_BITS-1:0];
        CFG_CONFIRM_HIT_COUNT: cfg_d.confirm_hit_count = cfg_data_i[15:0];
        CFG_MAX_COAST_MISSES:  cfg_d.max_coast_misses  = cfg_data_i[15:0];
        CFG_MIN_QUALITY:       cfg_d.min_quality       = cfg_data_i[Q_BITS-1:0];
        CFG_MAX_TRACK_RANGE:   cfg_d.max_track_range   = cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.quality_boost     <= 17'd6554;
      cfg_q.quality_decay     <= 17'd58982;
      cfg_q.confirm_hit_count <= 16'd3;
      cfg_q.max_coast_misses  <= 16'd5;
      cfg_q.min_quality       <= 17'd6554;
      cfg_q.max_track_range   <= 20'd20000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/tlt_dwell.sv
module tlt_dwell (
  input  logic              clk_i,
  input  logic              en_i,
  input  tlt_pkg::item_t    item_i,
  input  tlt_pkg::entry_t   entry_i,
  input  tlt_pkg::cfg_t     cfg_i,
  output logic              wr_en_o,
  output tlt_pkg::entry_t   wr_entry_o,
  output tlt_pkg::result_t  result_o
);
  import tlt_pkg::*;

  typedef struct packed {
    op_e               op;
    logic [5:0]        slot;
    logic              free;
    status_e           st;
    cnt_t              h;
    cnt_t              m;
    logic [Q_BITS-1:0] q;
    logic [33:0]       prod;
    logic [31:0]       sqx;
    logic [31:0]       sqy;
    logic [31:0]       sqz;
    logic              range_gt;
    logic              tr_hi;
    logic              cv_hi;
    logic              ca_hi;
  } stage_b_t;

  stage_b_t          b_d, b_q;
  logic [Q_BITS:0]   qsum;
  logic [CW-1:0]     init_h_w;
  logic signed [31:0] sqx_s, sqy_s, sqz_s;
  logic [17:0]       prod_hi;
  logic [Q_BITS-1:0] q_decay, q_c;
  logic [31:0]       spd2;
  status_e           st_c;
  logic              drop;
  class_e            cls_c;

  // Stage B: counters, quality add, decay product and squared velocities
  always_comb begin
    sqx_s = $signed(item_i.vel_x) * $signed(item_i.vel_x);
    sqy_s = $signed(item_i.vel_y) * $signed(item_i.vel_y);
    sqz_s = $signed(item_i.vel_z) * $signed(item_i.vel_z);
    init_h_w = CW'(item_i.init_hits);

    b_d.op       = item_i.op;
    b_d.slot     = item_i.slot;
    b_d.free     = (entry_i.status == ST_FREE);
    b_d.st       = entry_i.status;
    b_d.h        = entry_i.hits;
    b_d.m        = entry_i.misses;
    b_d.prod     = 34'(entry_i.quality) * 34'(cfg_i.quality_decay);
    b_d.sqx      = sqx_s;
    b_d.sqy      = sqy_s;
    b_d.sqz      = sqz_s;
    b_d.range_gt = (item_i.range_m > cfg_i.max_track_range);
    b_d.tr_hi    = (item_i.turn_prob > PROB_0P4);
    b_d.cv_hi    = (item_i.cv_prob > PROB_0P3);
    b_d.ca_hi    = (item_i.ca_prob > PROB_0P3);

    qsum = {1'b0, entry_i.quality} + {1'b0, cfg_i.quality_boost};
    b_d.q = (qsum > {1'b0, Q_ONE}) ? Q_ONE : qsum[Q_BITS-1:0];

    if (item_i.op == OP_CREATE) begin
      // saturate the starting values
      b_d.st = ST_TENT;
      b_d.q  = (item_i.init_quality > Q_ONE) ? Q_ONE : item_i.init_quality;
      b_d.h  = (init_h_w > CW'(CNT_MAX)) ? CNT_MAX : init_h_w[COUNT_BITS-1:0];
      b_d.m  = '0;
    end else if (item_i.hit) begin
      if (entry_i.hits != CNT_MAX) begin
        b_d.h = entry_i.hits + cnt_t'(1);
      end
      b_d.m = '0;
    end else begin
      if (entry_i.misses != CNT_MAX) begin
        b_d.m = entry_i.misses + cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_q <= b_d;
    end
  end

  // Stage C: quality pick, status move, drop test and classification
  always_comb begin
    prod_hi = b_q.prod[33:16];
    q_decay = (prod_hi > {1'b0, Q_ONE}) ? Q_ONE : prod_hi[Q_BITS-1:0];
    q_c     = (b_q.m == '0) ? b_q.q : q_decay;
    spd2    = b_q.sqx + b_q.sqy + b_q.sqz;

    st_c = b_q.st;
    unique case (b_q.st)
      ST_TENT: begin
        if (CW'(b_q.h) >= CW'(cfg_i.confirm_hit_count)) st_c = ST_CONF;
      end
      ST_CONF: begin
        if (b_q.m != '0) st_c = ST_COAST;
      end
      ST_COAST: begin
        if (b_q.m == '0) st_c = ST_CONF;
      end
      ST_FREE: st_c = ST_FREE;
    endcase

    drop = (CW'(b_q.m) >= CW'(cfg_i.max_coast_misses)) ||
           (q_c < cfg_i.min_quality) || b_q.range_gt;

    priority if (spd2 < SPD2_2) begin
      cls_c = CLS_CLUTTER;
    end else if (b_q.tr_hi && spd2 > SPD2_5 && spd2 < SPD2_30) begin
      cls_c = CLS_ROTARY;
    end else if (b_q.cv_hi && spd2 > SPD2_15 && spd2 < SPD2_80) begin
      cls_c = CLS_FIXED_WING;
    end else if (spd2 > SPD2_5 && spd2 < SPD2_25 && b_q.ca_hi) begin
      cls_c = CLS_BIRD;
    end else begin
      cls_c = CLS_UNKNOWN;
    end

    if (drop) begin
      st_c  = ST_FREE;
      cls_c = CLS_UNKNOWN;
    end

    result_o.slot = b_q.slot;
    result_o.code = RC_OK;
    wr_en_o       = 1'b1;

    if (b_q.op == OP_CREATE) begin
      wr_entry_o.status  = ST_TENT;
      wr_entry_o.quality = b_q.q;
      wr_entry_o.hits    = b_q.h;
      wr_entry_o.misses  = '0;
      wr_entry_o.cls     = CLS_UNKNOWN;
    end else begin
      wr_entry_o.status  = st_c;
      wr_entry_o.quality = q_c;
      wr_entry_o.hits    = b_q.h;
      wr_entry_o.misses  = b_q.m;
      wr_entry_o.cls     = cls_c;
    end

    result_o.status    = wr_entry_o.status;
    result_o.cls       = wr_entry_o.cls;
    result_o.quality   = wr_entry_o.quality;
    result_o.hit_total = cnt_to16(wr_entry_o.hits);
    result_o.miss_run  = cnt_to16(wr_entry_o.misses);

    // An update of a free slot leaves the table alone
    if (b_q.op == OP_UPDATE && b_q.free) begin
      wr_en_o            = 1'b0;
      result_o.status    = ST_FREE;
      result_o.cls       = CLS_UNKNOWN;
      result_o.quality   = '0;
      result_o.hit_total = '0;
      result_o.miss_run  = '0;
      result_o.code      = RC_FREE_SLOT;
    end
  end

endmodule

FILE: hdl/track_lifecycle_table.sv
// Channel   Direction  Handshake              Payload
// in        sink       in_valid_i/in_stall_o  op, slot, hit, init values, range, velocity, probs
// out       source     out_valid_o/out_stall_i slot, status, class, quality, counts, code
// cfg       sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Each item passes the table read and stage B (product and squares), then stage C
// (decide and write back), before its result is loaded.
// A new item is not accepted while the previous one is in the read and stage B step;
// the single read-modify-write of the slot table sets that limit, with the write
// forwarded to a following read of the same slot.
// Reset clears the slot valid bits, so every slot reads as free; no clearing pass.
// A stalled output holds stage C and then the input.
module track_lifecycle_table (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               op_i,
  input  logic [5:0]                         slot_i,
  input  logic                               hit_i,
  input  logic [16:0]                        init_quality_i,
  input  logic [15:0]                        init_hits_i,
  input  logic [19:0]                        range_m_i,
  input  logic signed [15:0]                 vel_x_i,
  input  logic signed [15:0]                 vel_y_i,
  input  logic signed [15:0]                 vel_z_i,
  input  logic [16:0]                        cv_prob_i,
  input  logic [16:0]                        ca_prob_i,
  input  logic [16:0]                        turn_prob_i,

  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [5:0]                         out_slot_o,
  output logic [1:0]                         track_status_o,
  output logic [2:0]                         track_class_o,
  output logic [16:0]                        track_quality_o,
  output logic [15:0]                        hit_total_o,
  output logic [15:0]                        miss_run_o,
  output logic                               result_code_o,

  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tlt_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [tlt_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);
  import tlt_pkg::*;

  cfg_t                   cfg;
  item_t                  item_in, item_q;
  logic                   s1_q, s2_q, out_valid_q;
  logic                   fwd_q, fwd_d;
  entry_t                 fwd_entry_q;
  logic [TRACK_SLOTS-1:0] valid_q, valid_d;
  logic                   accept, commit;
  logic [SLOT_BITS-1:0]   in_idx, s1_idx, wr_idx;
  logic [ENTRY_BITS-1:0]  rd_data;
  entry_t                 rd_entry, cur_entry;
  logic                   wr_en, ram_we;
  entry_t                 wr_entry;
  result_t                result, out_q;

  tlt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Gather the input item
  always_comb begin
    item_in.op           = op_e'(op_i);
    item_in.slot         = slot_i;
    item_in.hit          = hit_i;
    item_in.init_quality = init_quality_i;
    item_in.init_hits    = init_hits_i;
    item_in.range_m      = range_m_i;
    item_in.vel_x        = vel_x_i;
    item_in.vel_y        = vel_y_i;
    item_in.vel_z        = vel_z_i;
    item_in.cv_prob      = cv_prob_i;
    item_in.ca_prob      = ca_prob_i;
    item_in.turn_prob    = turn_prob_i;
  end

  // Pipeline control: one item in the read stage at a time
  assign commit     = s2_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_q || (s2_q && !commit);
  assign accept     = in_valid_i && !in_stall_o;

  assign in_idx = slot_i[SLOT_BITS-1:0];
  assign s1_idx = item_q.slot[SLOT_BITS-1:0];
  assign wr_idx = result.slot[SLOT_BITS-1:0];
  assign ram_we = commit && wr_en;

  // Forward the entry being written to a read of the same slot
  assign fwd_d = ram_we && (wr_idx == in_idx);

  tlt_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (TRACK_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx),
    .wdata_i (wr_entry),
    .re_i    (accept),
    .raddr_i (in_idx),
    .rdata_o (rd_data)
  );

  // Merge forwarding and slot valid bits
  always_comb begin
    rd_entry  = entry_t'(rd_data);
    cur_entry = fwd_q ? fwd_entry_q : rd_entry;
    if (!valid_q[s1_idx]) begin
      cur_entry.status = ST_FREE;
    end
  end

  tlt_dwell u_dwell (
    .clk_i      (clk_i),
    .en_i       (s1_q),
    .item_i     (item_q),
    .entry_i    (cur_entry),
    .cfg_i      (cfg),
    .wr_en_o    (wr_en),
    .wr_entry_o (wr_entry),
    .result_o   (result)
  );

  // Mark slots that have been written
  always_comb begin
    valid_d = valid_q;
    if (ram_we) begin
      valid_d[wr_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= 1'b0;
      s2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_q       <= 1'b0;
      valid_q     <= '0;
    end else begin
      s1_q        <= accept;
      s2_q        <= s1_q || (s2_q && !commit);
      out_valid_q <= commit || (out_valid_q && out_stall_i);
      if (accept) begin
        fwd_q <= fwd_d;
      end
      valid_q     <= valid_d;
    end
  end

  // Hold the item and the forwarded entry
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q      <= item_in;
      fwd_entry_q <= wr_entry;
    end
    if (commit) begin
      out_q <= result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_slot_o      = out_q.slot;
  assign track_status_o  = out_q.status;
  assign track_class_o   = out_q.cls;
  assign track_quality_o = out_q.quality;
  assign hit_total_o     = out_q.hit_total;
  assign miss_run_o      = out_q.miss_run;
  assign result_code_o   = out_q.code;

  // A free-slot error carries an empty result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_code_o == RC_FREE_SLOT) |->
      (track_status_o == ST_FREE && track_quality_o == '0 && hit_total_o == '0))
    else $error("free-slot result carries track data");

  // A result appears only after the decide stage held an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s2_q))
    else $error("result without an item in the decide stage");

  // Forwarding only follows a write-back in the same cycle as acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_q && fwd_q) |-> $past(s2_q && commit))
    else $error("forwarded entry without a write-back");

  // Quality never exceeds 1.0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (track_quality_o <= Q_ONE))
    else $error("track quality above 1.0");

endmodule

FILE: bench/track_lifecycle_table_tb.sv
module track_lifecycle_table_tb;
  import tlt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        op_i = 1'b0;
  logic [5:0]  slot_i = '0;
  logic        hit_i = 1'b0;
  logic [16:0] init_quality_i = '0;
  logic [15:0] init_hits_i = '0;
  logic [19:0] range_m_i = '0;
  logic signed [15:0] vel_x_i = '0;
  logic signed [15:0] vel_y_i = '0;
  logic signed [15:0] vel_z_i = '0;
  logic [16:0] cv_prob_i = '0;
  logic [16:0] ca_prob_i = '0;
  logic [16:0] turn_prob_i = '0;

  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [5:0]  out_slot_o;
  logic [1:0]  track_status_o;
  logic [2:0]  track_class_o;
  logic [16:0] track_quality_o;
  logic [15:0] hit_total_o;
  logic [15:0] miss_run_o;
  logic        result_code_o;

  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;

  // Shadow copy of the track table and its thresholds
  status_e     status_tbl [TRACK_SLOTS];
  logic [16:0] quality_tbl [TRACK_SLOTS];
  cnt_t        hits_tbl [TRACK_SLOTS];
  cnt_t        miss_tbl [TRACK_SLOTS];
  class_e      class_tbl [TRACK_SLOTS];

  logic [16:0] boost_q = 17'd6554;
  logic [16:0] decay_q = 17'd58982;
  logic [15:0] confirm_hits = 16'd3;
  logic [15:0] coast_limit = 16'd5;
  logic [16:0] quality_floor = 17'd6554;
  logic [19:0] range_limit = 20'd20000;

  item_t   pending_items[$];
  result_t expected_results[$];
  item_t   offered;
  result_t oldest_result;

  int idle_pct = 0;
  int stall_pct = 0;
  int hit_pct = 70;
  int hot_base = 0;
  int mismatches = 0;
  int cycle_count = 0;

  track_lifecycle_table uut (.*);

  always #1 clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < TRACK_SLOTS; i++) status_tbl[i] = ST_FREE;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Advance the table by one item and return the slot report it produces
  function automatic result_t track_table_step(item_t it);
    result_t     r;
    status_e     st;
    class_e      cls;
    logic [16:0] q;
    cnt_t        h;
    cnt_t        m;
    logic [31:0] boosted;
    logic [63:0] decayed;
    longint      vx;
    longint      vy;
    longint      vz;
    longint      speed2;
    r = '0;
    r.slot = it.slot;
    r.status = ST_FREE;
    r.cls = CLS_UNKNOWN;
    r.code = RC_OK;
    if (it.op == OP_CREATE) begin
      q = (it.init_quality > Q_ONE) ? Q_ONE : it.init_quality;
      status_tbl[it.slot] = ST_TENT;
      quality_tbl[it.slot] = q;
      hits_tbl[it.slot] = it.init_hits;
      miss_tbl[it.slot] = '0;
      class_tbl[it.slot] = CLS_UNKNOWN;
      r.status = ST_TENT;
      r.quality = q;
      r.hit_total = it.init_hits;
      return r;
    end
    st = status_tbl[it.slot];
    if (st == ST_FREE) begin
      r.code = RC_FREE_SLOT;
      return r;
    end
    q = quality_tbl[it.slot];
    h = hits_tbl[it.slot];
    m = miss_tbl[it.slot];
    // Record the dwell outcome with saturating counters
    if (it.hit) begin
      if (h != CNT_MAX) h = h + 1'b1;
      m = '0;
    end else if (m != CNT_MAX) begin
      m = m + 1'b1;
    end
    // Move quality: boost on a clean run, decay otherwise, both capped at one
    if (m == 0) begin
      boosted = 32'(q) + 32'(boost_q);
      q = (boosted > 32'(Q_ONE)) ? Q_ONE : boosted[16:0];
    end else begin
      decayed = (64'(q) * 64'(decay_q)) >> 16;
      q = (decayed > 64'(Q_ONE)) ? Q_ONE : decayed[16:0];
    end
    if (st == ST_TENT) begin
      if (h >= confirm_hits) st = ST_CONF;
    end else if (st == ST_CONF) begin
      if (m != 0) st = ST_COAST;
    end else if (m == 0) begin
      st = ST_CONF;
    end
    // Drop the track or classify it from squared speed and mode weights
    if (m >= coast_limit || q < quality_floor || it.range_m > range_limit) begin
      st = ST_FREE;
      cls = CLS_UNKNOWN;
    end else begin
      vx = $signed(it.vel_x);
      vy = $signed(it.vel_y);
      vz = $signed(it.vel_z);
      speed2 = vx * vx + vy * vy + vz * vz;
      if (speed2 < SPD2_2)
        cls = CLS_CLUTTER;
      else if (it.turn_prob > PROB_0P4 && speed2 > SPD2_5 && speed2 < SPD2_30)
        cls = CLS_ROTARY;
      else if (it.cv_prob > PROB_0P3 && speed2 > SPD2_15 && speed2 < SPD2_80)
        cls = CLS_FIXED_WING;
      else if (speed2 > SPD2_5 && speed2 < SPD2_25 && it.ca_prob > PROB_0P3)
        cls = CLS_BIRD;
      else
        cls = CLS_UNKNOWN;
    end
    status_tbl[it.slot] = st;
    quality_tbl[it.slot] = q;
    hits_tbl[it.slot] = h;
    miss_tbl[it.slot] = m;
    class_tbl[it.slot] = cls;
    r.status = st;
    r.cls = cls;
    r.quality = q;
    r.hit_total = h;
    r.miss_run = m;
    return r;
  endfunction

  // Draw one item, mostly aimed at a small window of live slots
  function automatic item_t roll_dwell();
    item_t it;
    int    bound;
    int    vel_mode;
    it = '0;
    it.op = ($urandom_range(99) < 22) ? OP_CREATE : OP_UPDATE;
    it.slot = ($urandom_range(99) < 80) ? 6'(hot_base + $urandom_range(5)) : 6'($urandom);
    it.hit = ($urandom_range(99) < hit_pct);
    case ($urandom_range(9))
      0: it.init_quality = 17'($urandom_range(65537, 131071));
      1: it.init_quality = 17'($urandom_range(0, 10000));
      default: it.init_quality = 17'($urandom_range(20000, 65536));
    endcase
    it.init_hits = ($urandom_range(99) < 90) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    case ($urandom_range(19))
      0: it.range_m = 20'($urandom);
      1: it.range_m = range_limit;
      2: it.range_m = range_limit + 1'b1;
      default: it.range_m = 20'($urandom_range(0, range_limit));
    endcase
    vel_mode = $urandom_range(3);
    case (vel_mode)
      0: bound = 20;
      1: bound = 300;
      2: bound = 900;
      default: bound = 0;
    endcase
    if (vel_mode == 3) begin
      it.vel_x = 16'($urandom);
      it.vel_y = 16'($urandom);
      it.vel_z = 16'($urandom);
    end else begin
      it.vel_x = 16'($urandom_range(0, 2 * bound) - bound);
      it.vel_y = 16'($urandom_range(0, 2 * bound) - bound);
      it.vel_z = 16'($urandom_range(0, 2 * bound) - bound);
    end
    it.cv_prob = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
    it.ca_prob = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
    it.turn_prob = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
    return it;
  endfunction

  task automatic queue_item(op_e op, logic [5:0] slot, logic hit, logic [16:0] iq,
                            logic [15:0] ih, logic [19:0] rng, logic [15:0] vx,
                            logic [15:0] vy, logic [15:0] vz, logic [16:0] cv,
                            logic [16:0] ca, logic [16:0] tr);
    item_t it;
    it.op = op;
    it.slot = slot;
    it.hit = hit;
    it.init_quality = iq;
    it.init_hits = ih;
    it.range_m = rng;
    it.vel_x = vx;
    it.vel_y = vy;
    it.vel_z = vz;
    it.cv_prob = cv;
    it.ca_prob = ca;
    it.turn_prob = tr;
    pending_items = {pending_items, it};
  endtask

  // Hold until the table is quiet, then let the pipeline settle
  task automatic drain_table();
    @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic random_phase(int count);
    repeat (count) pending_items = {pending_items, roll_dwell()};
    drain_table();
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [19:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_QUALITY_BOOST:     boost_q = val[16:0];
      CFG_QUALITY_DECAY:     decay_q = val[16:0];
      CFG_CONFIRM_HIT_COUNT: confirm_hits = val[15:0];
      CFG_MAX_COAST_MISSES:  coast_limit = val[15:0];
      CFG_MIN_QUALITY:       quality_floor = val[16:0];
      CFG_MAX_TRACK_RANGE:   range_limit = val;
      default: ;
    endcase
  endtask

  task automatic set_thresholds(int boost, int decay, int confirm, int coast, int floor_q,
                                int max_rng);
    write_reg(CFG_QUALITY_BOOST, 20'(boost));
    write_reg(CFG_QUALITY_DECAY, 20'(decay));
    write_reg(CFG_CONFIRM_HIT_COUNT, 20'(confirm));
    write_reg(CFG_MAX_COAST_MISSES, 20'(coast));
    write_reg(CFG_MIN_QUALITY, 20'(floor_q));
    write_reg(CFG_MAX_TRACK_RANGE, 20'(max_rng));
    @(negedge clk_i);
  endtask

  // Offer pending items; predict each one as it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o)
        expected_results = {expected_results, track_table_step(offered)};
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
          offered = pending_items.pop_front();
          in_valid_i <= 1'b1;
          op_i <= offered.op;
          slot_i <= offered.slot;
          hit_i <= offered.hit;
          init_quality_i <= offered.init_quality;
          init_hits_i <= offered.init_hits;
          range_m_i <= offered.range_m;
          vel_x_i <= offered.vel_x;
          vel_y_i <= offered.vel_y;
          vel_z_i <= offered.vel_z;
          cv_prob_i <= offered.cv_prob;
          ca_prob_i <= offered.ca_prob;
          turn_prob_i <= offered.turn_prob;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Check each slot report against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: report for slot %0d with nothing outstanding", $time, out_slot_o);
          mismatches++;
        end else begin
          oldest_result = expected_results.pop_front();
          compare_field("out_slot", oldest_result.slot, out_slot_o);
          compare_field("track_status", oldest_result.status, track_status_o);
          compare_field("track_class", oldest_result.cls, track_class_o);
          compare_field("track_quality", oldest_result.quality, track_quality_o);
          compare_field("hit_total", oldest_result.hit_total, hit_total_o);
          compare_field("miss_run", oldest_result.miss_run, miss_run_o);
          compare_field("result_code", oldest_result.code, result_code_o);
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    wait (rst_ni);
    @(negedge clk_i);

    // Directed: free-slot updates, create saturation, every class, status moves
    queue_item(OP_UPDATE, 6'd0, 1'b1, 17'd0, 16'd0, 20'd100, 16'd0, 16'd0, 16'd0,
               17'd0, 17'd0, 17'd0);
    queue_item(OP_UPDATE, 6'd63, 1'b0, 17'd0, 16'd0, 20'd0, 16'd0, 16'd0, 16'd0,
               17'd0, 17'd0, 17'd0);
    queue_item(OP_CREATE, 6'd0, 1'b0, 17'h1FFFF, 16'd0, 20'd0, 16'd0, 16'd0, 16'd0,
               17'd0, 17'd0, 17'd0);
    queue_item(OP_CREATE, 6'd63, 1'b1, 17'd0, 16'hFFFF, 20'hFFFFF, 16'hFFFF, 16'hFFFF,
               16'hFFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
    queue_item(OP_UPDATE, 6'd63, 1'b1, 17'd0, 16'd0, 20'd100, 16'd0, 16'd0, 16'd0,
               17'd0, 17'd0, 17'd0);
    queue_item(OP_UPDATE, 6'd0, 1'b1, 17'd0, 16'd0, 20'd100, 16'd200, 16'd0, 16'd0,
               17'd0, 17'd0, 17'd30000);
    queue_item(OP_UPDATE, 6'd0, 1'b1, 17'd0, 16'd0, 20'd100, 16'd600, 16'd0, 16'd0,
               17'd20000, 17'd0, 17'd0);
    queue_item(OP_UPDATE, 6'd0, 1'b1, 17'd0, 16'd0, 20'd100, 16'd0, -16'sd200, 16'd0,
               17'd0, 17'd20000, 17'd0);
    queue_item(OP_UPDATE, 6'd0, 1'b0, 17'd0, 16'd0, 20'd100, 16'h8000, 16'h8000, 16'h8000,
               17'd65536, 17'd65536, 17'd65536);
    queue_item(OP_UPDATE, 6'd0, 1'b1, 17'd0, 16'd0, 20'd20000, 16'd32, 16'd0, 16'd0,
               17'd0, 17'd0, 17'd0);
    queue_item(OP_UPDATE, 6'd0, 1'b1, 17'd0, 16'd0, 20'd20001, 16'd0, 16'd0, 16'd0,
               17'd0, 17'd0, 17'd0);
    queue_item(OP_UPDATE, 6'd0, 1'b1, 17'd0, 16'd0, 20'd0, 16'd0, 16'd0, 16'd0,
               17'd0, 17'd0, 17'd0);
    queue_item(OP_CREATE, 6'd5, 1'b0, 17'd7000, 16'd0, 20'd0, 16'd0, 16'd0, 16'd0,
               17'd0, 17'd0, 17'd0);
    queue_item(OP_UPDATE, 6'd5, 1'b0, 17'd0, 16'd0, 20'd0, 16'd0, 16'd0, 16'd0,
               17'd0, 17'd0, 17'd0);
    queue_item(OP_CREATE, 6'd7, 1'b0, 17'd65536, 16'd0, 20'd0, 16'd0, 16'd0, 16'd0,
               17'd0, 17'd0, 17'd0);
    repeat (5)
      queue_item(OP_UPDATE, 6'd7, 1'b0, 17'd0, 16'd0, 20'd500, 16'd100, 16'd100, 16'd0,
                 17'd0, 17'd0, 17'd0);
    queue_item(OP_CREATE, 6'd63, 1'b0, 17'd30000, 16'd1, 20'd0, 16'd0, 16'd0, 16'd0,
               17'd0, 17'd0, 17'd0);
    queue_item(OP_UPDATE, 6'd63, 1'b1, 17'd0, 16'd0, 20'hFFFFF, 16'h7FFF, 16'h7FFF,
               16'h7FFF, 17'd0, 17'd0, 17'd0);
    drain_table();

    // Reset thresholds, moderate idling on both sides
    idle_pct = 26;
    stall_pct = 26;
    hot_base = $urandom_range(0, 58);
    random_phase(126);

    // Loosest thresholds, no idling at all
    set_thresholds(65536, 65536, 1, 65535, 0, 1048575);
    idle_pct = 0;
    stall_pct = 0;
    hit_pct = 50;
    hot_base = $urandom_range(0, 58);
    random_phase(126);

    // Tightest thresholds
    set_thresholds(0, 0, 65535, 1, 65536, 0);
    idle_pct = 26;
    stall_pct = 26;
    hit_pct = 80;
    hot_base = $urandom_range(0, 58);
    random_phase(126);

    // Random mid-range thresholds, with a pause halfway through
    set_thresholds($urandom_range(0, 20000), $urandom_range(40000, 65536),
                   $urandom_range(1, 6), $urandom_range(2, 8), $urandom_range(0, 20000),
                   $urandom_range(1000, 60000));
    hit_pct = 65;
    hot_base = $urandom_range(0, 58);
    random_phase(63);
    random_phase(63);

    // Back to the reset thresholds
    set_thresholds(6554, 58982, 3, 5, 6554, 20000);
    hit_pct = 60;
    hot_base = $urandom_range(0, 58);
    random_phase(126);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
